/* design/crast_pkg.sv */
// shared types, widths and helpers for the circle rasterizer
package crast_pkg;

    localparam int RADIUS_BITS = 8;
    localparam int COORD_BITS  = 10;
    localparam int COLOR_W     = 24;
    localparam int MODE_W      = 2;
    localparam int X_W         = RADIUS_BITS + 1;
    localparam int Y_W         = RADIUS_BITS + 2;
    localparam int D_W         = RADIUS_BITS + 4;
    localparam int ERR_W       = D_W + 2;
    localparam int OUT_W       = COORD_BITS + 2;
    localparam int R_PAD       = RADIUS_BITS + (RADIUS_BITS % 2);

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [MODE_W-1:0]
    {
        MODE_OUTLINE = 2'd0,
        MODE_FILLED  = 2'd1,
        MODE_STRIPED = 2'd2
    } mode_t;

    typedef struct packed
    {
        cmd_t                   command;
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [RADIUS_BITS-1:0] radius;
        logic [MODE_W-1:0]      mode;
        logic [COLOR_W-1:0]     color_a;
        logic [COLOR_W-1:0]     color_b;
    } cmd_item_t;

    typedef struct packed
    {
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] lower_y;
        logic signed [OUT_W-1:0] upper_y;
        logic [COLOR_W-1:0]      pixel_color;
        logic                    last;
    } pix_item_t;

    typedef struct packed
    {
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [RADIUS_BITS-1:0] radius;
        logic [X_W-1:0]         step_x;
        logic signed [Y_W-1:0]  step_y;
        logic signed [D_W-1:0]  delta;
        logic [MODE_W-1:0]      mode;
        logic [COLOR_W-1:0]     color_a;
        logic [COLOR_W-1:0]     color_b;
        logic                   busy;
    } gen_state_t;

    // radius mod 3 by summing base-4 digits, since 4 is 1 mod 3
    function automatic logic [1:0] mod3(input logic [RADIUS_BITS-1:0] r);
        logic [R_PAD-1:0] rp;
        logic [2:0]       acc;
        rp  = R_PAD'(r);
        acc = 3'd0;
        for (int i = 0; i < R_PAD / 2; i++)
        begin
            acc = acc + {1'b0, rp[2*i +: 2]};
            if (acc >= 3'd3)
            begin
                acc = acc - 3'd3;
            end
        end
        return acc[1:0];
    endfunction

endpackage

/* design/crast_step.sv */
// one midpoint circle iteration: point group out, next generator state
module crast_step
(
    input  crast_pkg::gen_state_t cur,
    output crast_pkg::gen_state_t nxt,
    output crast_pkg::pix_item_t  res
);

    logic [crast_pkg::X_W-1:0]         x1;
    logic signed [crast_pkg::Y_W-1:0]  y1;
    logic signed [crast_pkg::Y_W-1:0]  y_dec;
    logic signed [crast_pkg::D_W-1:0]  d1;
    logic signed [crast_pkg::D_W-1:0]  x1_ext;
    logic signed [crast_pkg::D_W-1:0]  y_ext;
    logic signed [crast_pkg::D_W-1:0]  y_dec_ext;
    logic signed [crast_pkg::ERR_W-1:0] err;
    logic                              more;
    logic [crast_pkg::RADIUS_BITS-1:0] r_dec;
    logic                              filled;
    logic                              grp_last;
    // step selection
    logic                              take_x;
    logic                              take_y;

    assign x1        = cur.step_x + crast_pkg::X_W'(1);
    assign y_dec     = cur.step_y - crast_pkg::Y_W'(1);
    assign x1_ext    = $signed(crast_pkg::D_W'(x1));
    assign y_ext     = crast_pkg::D_W'(cur.step_y);
    assign y_dec_ext = crast_pkg::D_W'(y_dec);
    assign err       = ((crast_pkg::ERR_W'(cur.delta) + crast_pkg::ERR_W'(cur.step_y)) <<< 1)
                     - crast_pkg::ERR_W'(1);
    assign filled    = (cur.mode == crast_pkg::MODE_FILLED)
                    || (cur.mode == crast_pkg::MODE_STRIPED);
    assign r_dec     = cur.radius - crast_pkg::RADIUS_BITS'(1);

    assign take_x = (cur.delta < 0) && (err <= 0);
    assign take_y = (cur.delta > 0) && (err > 0);

    always_comb
    begin
        nxt = cur;
        if (take_x)
        begin
            nxt.step_x = x1;
            d1         = cur.delta + (x1_ext <<< 1) + crast_pkg::D_W'(1);
            y1         = cur.step_y;
        end
        else if (take_y)
        begin
            nxt.step_x = cur.step_x;
            d1         = cur.delta - ((y_dec_ext <<< 1) + crast_pkg::D_W'(1));
            y1         = y_dec;
        end
        else
        begin
            nxt.step_x = x1;
            d1         = cur.delta + ((x1_ext - y_ext) <<< 1);
            y1         = y_dec;
        end
        nxt.step_y = y1;
        nxt.delta  = d1;
        more       = filled && (cur.radius != '0);
        grp_last   = 1'b0;
        // circle done once y drops below zero
        if (y1 < 0)
        begin
            if (more)
            begin
                nxt.radius = r_dec;
                nxt.step_x = '0;
                nxt.step_y = $signed(crast_pkg::Y_W'(r_dec));
                nxt.delta  = crast_pkg::D_W'(1) - (crast_pkg::D_W'(r_dec) << 1);
            end
            else
            begin
                nxt.busy = 1'b0;
                grp_last = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.right_x = $signed(crast_pkg::OUT_W'(cur.center_x)) + crast_pkg::OUT_W'(cur.step_x);
        res.left_x  = $signed(crast_pkg::OUT_W'(cur.center_x)) - crast_pkg::OUT_W'(cur.step_x);
        res.lower_y = $signed(crast_pkg::OUT_W'(cur.center_y)) + crast_pkg::OUT_W'(cur.step_y);
        res.upper_y = $signed(crast_pkg::OUT_W'(cur.center_y)) - crast_pkg::OUT_W'(cur.step_y);
        res.last    = grp_last;
        if (cur.mode == crast_pkg::MODE_STRIPED && crast_pkg::mod3(cur.radius) == 2'd1)
        begin
            res.pixel_color = cur.color_b;
        end
        else
        begin
            res.pixel_color = cur.color_a;
        end
    end

endmodule

/* design/circle_rasterizer.sv */
// midpoint circle rasterizer top level: command channel in, point groups out
//
// cmd channel (cmd_valid / cmd_stall / cmd_data) carries commands. A start
// command latches centre, radius, mode and both colours and arms the
// generator; it produces no output. A step command, while armed, runs one
// midpoint iteration and produces one group of four symmetric points on the
// pix channel (pix_valid / pix_stall / pix_data). A step while idle is
// consumed with no output. In filled and striped modes the radii r..0 are
// walked in turn; last marks the final group of the whole shape.
// A group is registered and appears on pix in the cycle after its step transfer.
// Throughput: one command per cycle while cmd_stall is low; the iteration is a
// combinational update of the x, y and error registers feeding one output register.
// cmd_stall is raised only while the output register holds a group that
// the receiver is stalling, so commands wait and nothing is dropped.
// Reset clears all generator state to idle and empties the output register.
module circle_rasterizer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  crast_pkg::cmd_item_t  cmd_data,
    output logic                  pix_valid,
    input  logic                  pix_stall,
    output crast_pkg::pix_item_t  pix_data
);

    crast_pkg::gen_state_t state_reg;
    crast_pkg::gen_state_t state_next;
    crast_pkg::gen_state_t step_state;
    crast_pkg::pix_item_t  step_res;
    crast_pkg::pix_item_t  pix_reg;
    logic                  pix_valid_reg;
    logic                  cmd_xfer;
    logic                  pix_xfer;
    logic                  step_fire;

    crast_step u_step
    (
        .cur (state_reg),
        .nxt (step_state),
        .res (step_res)
    );

    assign cmd_stall = pix_valid_reg && pix_stall;
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign pix_xfer  = pix_valid_reg && !pix_stall;
    assign step_fire = cmd_xfer && (cmd_data.command == crast_pkg::CMD_STEP)
                    && state_reg.busy;

    always_comb
    begin
        state_next = state_reg;
        if (cmd_xfer)
        begin
            if (cmd_data.command == crast_pkg::CMD_START)
            begin
                state_next.center_x = cmd_data.center_x;
                state_next.center_y = cmd_data.center_y;
                state_next.radius   = cmd_data.radius;
                state_next.mode     = cmd_data.mode;
                state_next.color_a  = cmd_data.color_a;
                state_next.color_b  = cmd_data.color_b;
                state_next.step_x   = '0;
                state_next.step_y   = $signed(crast_pkg::Y_W'(cmd_data.radius));
                state_next.delta    = crast_pkg::D_W'(1)
                                    - (crast_pkg::D_W'(cmd_data.radius) << 1);
                state_next.busy     = 1'b1;
            end
            else if (state_reg.busy)
            begin
                state_next = step_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (step_fire)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (pix_xfer)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            pix_reg <= step_res;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_reg;

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer && (cmd_data.command == crast_pkg::CMD_START) |=> state_reg.busy)
        else $error("start transfer did not arm the generator");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && step_res.last |=> !state_reg.busy && pix_valid && pix_data.last)
        else $error("final group did not return the generator to idle");

    a_y_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.busy |-> !state_reg.step_y[crast_pkg::Y_W-1])
        else $error("step_y negative while busy");

    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.busy |-> state_reg.step_x <= crast_pkg::X_W'(state_reg.radius) + 1'b1)
        else $error("step_x beyond radius");

    a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer && (cmd_data.command == crast_pkg::CMD_STEP) && !state_reg.busy
        && !pix_valid_reg |=> !pix_valid)
        else $error("step while idle produced a group");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the midpoint circle rasterizer
module testbench;

    localparam int STRIPE_PERIOD = 3;
    localparam int WORK_ITEMS    = 850;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PRINT_MAX     = 40;

    typedef struct
    {
        crast_pkg::cmd_item_t cmd;
        bit                   typed;
        crast_pkg::pix_item_t want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_stall;
    crast_pkg::cmd_item_t cmd_data;
    logic                 pix_valid;
    logic                 pix_stall;
    crast_pkg::pix_item_t pix_data;

    // shape generator mirror
    logic [crast_pkg::COORD_BITS-1:0]  gen_cx      = '0;
    logic [crast_pkg::COORD_BITS-1:0]  gen_cy      = '0;
    logic [crast_pkg::RADIUS_BITS-1:0] gen_radius  = '0;
    int                                gen_x       = 0;
    int                                gen_y       = 0;
    int                                gen_delta   = 0;
    logic [crast_pkg::MODE_W-1:0]      gen_mode    = '0;
    logic [crast_pkg::COLOR_W-1:0]     gen_color_a = '0;
    logic [crast_pkg::COLOR_W-1:0]     gen_color_b = '0;
    bit                                gen_busy    = 1'b0;

    crast_pkg::pix_item_t pending_groups[$];
    plan_row_t            plan[$];
    int                   mismatch_count = 0;
    int                   work_count     = 0;
    int                   gap_style      = 0;
    int                   cycle_count    = 0;
    bit                   hold_req       = 1'b0;

    circle_rasterizer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data)
    );

    always #6 clk = ~clk;

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // one midpoint iteration per step; a start only latches
    task automatic trace_circle(input crast_pkg::cmd_item_t it, output bit emitted,
                                output crast_pkg::pix_item_t grp);
        int err;
        emitted = 1'b0;
        grp     = '0;
        if (it.command == crast_pkg::CMD_START)
        begin
            gen_cx      = it.center_x;
            gen_cy      = it.center_y;
            gen_mode    = it.mode;
            gen_color_a = it.color_a;
            gen_color_b = it.color_b;
            gen_radius  = it.radius;
            gen_x       = 0;
            gen_y       = int'(it.radius);
            gen_delta   = 1 - 2 * int'(it.radius);
            gen_busy    = 1'b1;
        end
        else if (gen_busy)
        begin
            emitted = 1'b1;
            if (gen_mode == crast_pkg::MODE_STRIPED && gen_radius % STRIPE_PERIOD == 1)
            begin
                grp.pixel_color = gen_color_b;
            end
            else
            begin
                grp.pixel_color = gen_color_a;
            end
            grp.right_x = crast_pkg::OUT_W'(int'(gen_cx) + gen_x);
            grp.left_x  = crast_pkg::OUT_W'(int'(gen_cx) - gen_x);
            grp.lower_y = crast_pkg::OUT_W'(int'(gen_cy) + gen_y);
            grp.upper_y = crast_pkg::OUT_W'(int'(gen_cy) - gen_y);
            err = 2 * (gen_delta + gen_y) - 1;
            if (gen_delta < 0 && err <= 0)
            begin
                gen_x++;
                gen_delta += 2 * gen_x + 1;
            end
            else if (gen_delta > 0 && err > 0)
            begin
                gen_y--;
                gen_delta -= 2 * gen_y + 1;
            end
            else
            begin
                gen_x++;
                gen_delta += 2 * (gen_x - gen_y);
                gen_y--;
            end
            grp.last = 1'b0;
            if (gen_y < 0)
            begin
                if ((gen_mode == crast_pkg::MODE_FILLED || gen_mode == crast_pkg::MODE_STRIPED)
                    && gen_radius > 0)
                begin
                    // next inner ring
                    gen_radius = gen_radius - 1'b1;
                    gen_x      = 0;
                    gen_y      = int'(gen_radius);
                    gen_delta  = 1 - 2 * int'(gen_radius);
                end
                else
                begin
                    gen_busy = 1'b0;
                    grp.last = 1'b1;
                end
            end
        end
    endtask

    function automatic crast_pkg::cmd_item_t rand_cmd(input crast_pkg::cmd_t c);
        crast_pkg::cmd_item_t it;
        it.command  = c;
        it.center_x = crast_pkg::COORD_BITS'($urandom);
        it.center_y = crast_pkg::COORD_BITS'($urandom);
        it.radius   = crast_pkg::RADIUS_BITS'($urandom);
        it.mode     = crast_pkg::MODE_W'($urandom);
        it.color_a  = crast_pkg::COLOR_W'($urandom);
        it.color_b  = crast_pkg::COLOR_W'($urandom);
        return it;
    endfunction

    function automatic crast_pkg::cmd_item_t start_cmd(input int cx, input int cy, input int r,
                                            input logic [crast_pkg::MODE_W-1:0] m,
                                            input logic [crast_pkg::COLOR_W-1:0] ca,
                                            input logic [crast_pkg::COLOR_W-1:0] cb);
        crast_pkg::cmd_item_t it;
        it.command  = crast_pkg::CMD_START;
        it.center_x = crast_pkg::COORD_BITS'(cx);
        it.center_y = crast_pkg::COORD_BITS'(cy);
        it.radius   = crast_pkg::RADIUS_BITS'(r);
        it.mode     = m;
        it.color_a  = ca;
        it.color_b  = cb;
        return it;
    endfunction

    function automatic crast_pkg::pix_item_t point_group(input int rx, input int lx,
                                              input int ly, input int uy,
                                              input logic [crast_pkg::COLOR_W-1:0] c,
                                              input bit fin);
        crast_pkg::pix_item_t g;
        g.right_x     = crast_pkg::OUT_W'(rx);
        g.left_x      = crast_pkg::OUT_W'(lx);
        g.lower_y     = crast_pkg::OUT_W'(ly);
        g.upper_y     = crast_pkg::OUT_W'(uy);
        g.pixel_color = c;
        g.last        = fin;
        return g;
    endfunction

    function automatic plan_row_t plan_row(input crast_pkg::cmd_item_t c, input bit typed,
                                           input crast_pkg::pix_item_t w);
        plan_row_t p;
        p.cmd   = c;
        p.typed = typed;
        p.want  = w;
        return p;
    endfunction

    // present one command, wait for the transfer, then predict and possibly idle
    task automatic offer_cmd(input crast_pkg::cmd_item_t it, input bit typed,
                             input crast_pkg::pix_item_t typed_grp);
        bit                   emitted;
        crast_pkg::pix_item_t grp;
        int                   p;
        int                   gap;
        cmd_valid <= 1'b1;
        cmd_data  <= it;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        trace_circle(it, emitted, grp);
        if (emitted)
        begin
            pending_groups.push_back(typed ? typed_grp : grp);
        end
        if (emitted || it.command == crast_pkg::CMD_START)
        begin
            work_count++;
            if (work_count == HOLD_AT)
            begin
                hold_req = 1'b1;
            end
        end
        gap = 0;
        if (gap_style != 0)
        begin
            p = $urandom_range(0, 99);
            if (p >= 92)
            begin
                gap = $urandom_range(8, 30);
            end
            else if (p >= 65)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // scoreboard on the point channel
    always @(posedge clk)
    begin
        crast_pkg::pix_item_t want;
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (pending_groups.size() == 0)
            begin
                log_mismatch("point group with nothing expected");
            end
            else
            begin
                want = pending_groups.pop_front();
                check_field("right_x", pix_data.right_x, want.right_x);
                check_field("left_x", pix_data.left_x, want.left_x);
                check_field("lower_y", pix_data.lower_y, want.lower_y);
                check_field("upper_y", pix_data.upper_y, want.upper_y);
                check_field("pixel_color", pix_data.pixel_color, want.pixel_color);
                check_field("last", pix_data.last, want.last);
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        int  run_len;
        int  style;
        int  hold_left;
        bit  hold_done;
        hold_done = 1'b0;
        pix_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req && !hold_done)
            begin
                // long hold so the output register fills and commands back up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0)
                begin
                    pix_stall <= 1'b1;
                    @(posedge clk);
                    hold_left--;
                end
            end
            run_len = $urandom_range(1, 50);
            style   = $urandom_range(0, 9);
            if (style == 9)
            begin
                run_len = $urandom_range(20, 60);
            end
            repeat (run_len)
            begin
                if (style <= 2)
                begin
                    pix_stall <= 1'b0;
                end
                else if (style == 9)
                begin
                    pix_stall <= 1'b1;
                end
                else
                begin
                    pix_stall <= ($urandom_range(0, 99) < 30);
                end
                @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        crast_pkg::cmd_item_t it;
        int                   pick;
        int                   n;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_data  <= '0;

        plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0));
        plan.push_back(plan_row(start_cmd(0, 0, 0, crast_pkg::MODE_OUTLINE,
                                          24'h5a5a5a, 24'ha5a5a5), 1'b0, '0));
        plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b1,
                                point_group(0, 0, 0, 0, 24'h5a5a5a, 1'b1)));
        plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0));
        plan.push_back(plan_row(start_cmd(1023, 1023, 255, crast_pkg::MODE_FILLED,
                                          24'hffffff, 24'h000000), 1'b0, '0));
        plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b1,
                                point_group(1023, 1023, 1278, 768, 24'hffffff, 1'b0)));
        plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0));
        // restart while the previous shape is still running
        plan.push_back(plan_row(start_cmd(0, 0, 255, crast_pkg::MODE_STRIPED,
                                          24'h000000, 24'hffffff), 1'b0, '0));
        plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b1,
                                point_group(0, 0, 255, -255, 24'h000000, 1'b0)));
        plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0));
        plan.push_back(plan_row(start_cmd(500, 300, 1, crast_pkg::MODE_STRIPED,
                                          24'h00ff00, 24'hff00ff), 1'b0, '0));
        repeat (5) plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0));
        // unused mode code acts as outline
        plan.push_back(plan_row(start_cmd(10, 20, 2, 2'd3, 24'habcdef, 24'h123456),
                                1'b0, '0));
        repeat (4) plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0));
        plan.push_back(plan_row(start_cmd(1023, 0, 3, crast_pkg::MODE_FILLED,
                                          24'h0f0f0f, 24'hf0f0f0), 1'b0, '0));
        repeat (2) plan.push_back(plan_row(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_style = 1;
        foreach (plan[i])
        begin
            offer_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
        end

        while (work_count < WORK_ITEMS)
        begin
            gap_style = $urandom_range(0, 3);
            pick      = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // whole shape, small enough to finish unless cut off at random
                it        = rand_cmd(crast_pkg::CMD_START);
                it.mode   = crast_pkg::MODE_W'($urandom_range(0, 3));
                it.radius = (it.mode == crast_pkg::MODE_FILLED
                             || it.mode == crast_pkg::MODE_STRIPED) ?
                            crast_pkg::RADIUS_BITS'($urandom_range(0, 9)) :
                            crast_pkg::RADIUS_BITS'($urandom_range(0, 48));
                offer_cmd(it, 1'b0, '0);
                while (gen_busy)
                begin
                    if ($urandom_range(0, 199) == 0)
                    begin
                        break;
                    end
                    offer_cmd(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0);
                end
            end
            else if (pick < 85)
            begin
                // random or maximum radius, usually cut short by the next start
                it = rand_cmd(crast_pkg::CMD_START);
                if ($urandom_range(0, 3) == 0)
                begin
                    it.radius = '1;
                end
                offer_cmd(it, 1'b0, '0);
                n = $urandom_range(1, 25);
                repeat (n) offer_cmd(rand_cmd(crast_pkg::CMD_STEP), 1'b0, '0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    offer_cmd(rand_cmd(crast_pkg::cmd_t'($urandom_range(0, 1))), 1'b0, '0);
            end
        end

        cmd_valid <= 1'b0;
        while (pending_groups.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
